// File: hdl/gm3_pkg.sv
package gm3_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int PIXEL_BITS = 8;

   localparam int COL_BITS      = $clog2(MAX_WIDTH);
   localparam int ROW_BITS      = 16;
   localparam int WIDTH_BITS    = 11;
   localparam int CSR_BITS      = 16;
   localparam int CSR_IDX_BITS  = 2;
   localparam int MODE_BITS     = 2;
   localparam int OUT_ROW_BITS  = 16;
   localparam int OUT_COL_BITS  = 10;
   localparam int VALUE_BITS    = 8;
   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = 40;

   localparam int RESET_WIDTH  = 1024;
   localparam int RESET_HEIGHT = 1024;

   // configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_MODE   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HEIGHT = 2'd2;

   // filter modes, the unused code acts as dilation
   localparam logic [MODE_BITS-1:0] MODE_DILATE   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_ERODE    = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_GRADIENT = 2'd2;

   typedef logic [PIXEL_BITS-1:0] pixel_type;
   typedef logic [COL_BITS-1:0]   col_type;
   typedef logic [ROW_BITS-1:0]   row_type;

   // one window column, top to bottom
   typedef struct packed {
      pixel_type upper;
      pixel_type middle;
      pixel_type lower;
   } column_type;

   // one line buffer word: rows r-2 and r-1 at one column
   typedef struct packed {
      pixel_type upper;
      pixel_type middle;
   } line_pair_type;

   typedef struct packed {
      row_type   row;
      col_type   col;
      pixel_type value;
   } result_type;

   // position of a pixel inside the frame
   typedef struct packed {
      logic r_ge1;
      logic r_ge2;
      logic c_ge1;
      logic c_ge2;
      logic c_last;
      logic r_last;
   } pos_flags_type;

   function automatic pixel_type column_max(column_type col);
      pixel_type m;
      m = (col.upper > col.middle) ? col.upper : col.middle;
      return (col.lower > m) ? col.lower : m;
   endfunction

   function automatic pixel_type column_min(column_type col);
      pixel_type m;
      m = (col.upper < col.middle) ? col.upper : col.middle;
      return (col.lower < m) ? col.lower : m;
   endfunction

endpackage

// File: hdl/gray_morphology_3x3_core.sv
// path: a pixel beat is registered in stage 1, then loaded into the result register once free
// throughput: one pixel per cycle while rsp_tready is high and each pixel yields at most one
//   result; a row end or a pixel of the last row yields up to three result beats and holds
//   the input until the single result register has handed them out at one beat per cycle
// reset: synchronous, active high; clears counters, pipeline and result valids, and sets
//   mode to dilate and the frame to 1024 x 1024; the line buffers are not cleared
module gray_morphology_3x3_core
   import gm3_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // pixel stream
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // pixel
   // result stream
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // out_row, out_col, value, zero pad
   output logic                     rsp_tlast,
   // configuration writes
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_BITS-1:0]      csr_wdata
);

   // configuration, frame size kept as last column and last row index
   logic [MODE_BITS-1:0] mode_ff,     mode_in;
   col_type              last_col_ff, last_col_in;
   row_type              last_row_ff, last_row_in;

   // position of the next input pixel
   col_type col_ff, col_in;
   row_type row_ff, row_in;

   // stage 1: pixel waiting for its line buffer column
   logic          s1_valid_ff, s1_valid_in;
   pixel_type     s1_pix_ff;
   col_type       s1_col_ff;
   row_type       s1_row_ff;
   pos_flags_type s1_flags_ff;

   // result register: three slots and the beats still pending
   result_type res_ff [3];
   result_type res_in [3];
   logic [2:0] pend_ff, pend_in;

   logic          accept_in;
   logic          rsp_take;
   logic          load;
   logic          emit_free;
   logic [2:0]    sel;
   logic [2:0]    pend_left;
   logic [2:0]    new_mask;
   pos_flags_type flags_now;
   result_type    res_out;

   logic [WIDTH_BITS-1:0] csr_width;
   row_type               csr_height;

   line_pair_type lb_q;
   line_pair_type lb_wr_data;
   column_type    cur_col;
   column_type    near_col;
   column_type    far_col;
   pixel_type     near_max, near_min, far_max, far_min;
   pixel_type     cur_max, cur_min;
   pixel_type     win_max, win_min;
   pixel_type     win_val;
   pixel_type     m01, n01;

   //---------------------------------------------------------------- handshakes
   assign rsp_take  = rsp_tvalid & rsp_tready;
   assign sel       = pend_ff & (~pend_ff + 3'd1);   // lowest pending slot
   assign pend_left = pend_ff & ~sel;
   assign emit_free = ((rsp_take ? pend_left : pend_ff) == 3'b000);
   assign load      = s1_valid_ff & emit_free;
   assign req_tready = ~s1_valid_ff | emit_free;
   assign accept_in = req_tvalid & req_tready;

   //---------------------------------------------------------------- configuration
   assign csr_width  = csr_wdata[WIDTH_BITS-1:0];
   assign csr_height = csr_wdata[ROW_BITS-1:0];

   always_comb begin
      mode_in     = mode_ff;
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MODE: begin
               mode_in = csr_wdata[MODE_BITS-1:0];
            end
            CSR_WIDTH: begin
               // zero counts as one column, too wide clamps to the buffer size
               if (csr_width == '0) begin
                  last_col_in = '0;
               end else if (csr_width > WIDTH_BITS'(MAX_WIDTH)) begin
                  last_col_in = COL_BITS'(MAX_WIDTH - 1);
               end else begin
                  last_col_in = COL_BITS'(csr_width - 1'b1);
               end
            end
            CSR_HEIGHT: begin
               // zero counts as one row
               if (csr_height == '0) begin
                  last_row_in = '0;
               end else begin
                  last_row_in = csr_height - 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   //---------------------------------------------------------------- raster counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_we && ((csr_index == CSR_WIDTH) || (csr_index == CSR_HEIGHT))) begin
         // a new frame size restarts the frame
         col_in = '0;
         row_in = '0;
      end else if (accept_in) begin
         if (col_ff == last_col_ff) begin
            col_in = '0;
            row_in = (row_ff == last_row_ff) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   assign flags_now.r_ge1  = (row_ff >= ROW_BITS'(1));
   assign flags_now.r_ge2  = (row_ff >= ROW_BITS'(2));
   assign flags_now.c_ge1  = (col_ff >= COL_BITS'(1));
   assign flags_now.c_ge2  = (col_ff >= COL_BITS'(2));
   assign flags_now.c_last = (col_ff == last_col_ff);
   assign flags_now.r_last = (row_ff == last_row_ff);

   //---------------------------------------------------------------- line buffers
   // read at accept, written back when the pixel leaves stage 1
   assign lb_wr_data.upper  = lb_q.middle;
   assign lb_wr_data.middle = s1_pix_ff;

   gm3_line_buffer u_line_buffer (
      .clock   (clock),
      .rd_en   (accept_in),
      .rd_addr (col_ff),
      .rd_data (lb_q),
      .wr_en   (load),
      .wr_addr (s1_col_ff),
      .wr_data (lb_wr_data)
   );

   //---------------------------------------------------------------- window cells
   // current column enters the near cell, the near cell hands to the far cell
   assign cur_col.upper  = lb_q.upper;
   assign cur_col.middle = lb_q.middle;
   assign cur_col.lower  = s1_pix_ff;

   gm3_column_cell u_cell_near (
      .clock    (clock),
      .reset    (reset),
      .shift_en (load),
      .col_in   (cur_col),
      .col_out  (near_col),
      .col_max  (near_max),
      .col_min  (near_min)
   );

   gm3_column_cell u_cell_far (
      .clock    (clock),
      .reset    (reset),
      .shift_en (load),
      .col_in   (near_col),
      .col_out  (far_col),
      .col_max  (far_max),
      .col_min  (far_min)
   );

   assign cur_max = column_max(cur_col);
   assign cur_min = column_min(cur_col);
   assign m01     = (near_max > far_max) ? near_max : far_max;
   assign n01     = (near_min < far_min) ? near_min : far_min;
   assign win_max = (cur_max > m01) ? cur_max : m01;
   assign win_min = (cur_min < n01) ? cur_min : n01;

   always_comb begin
      unique case (mode_ff)
         MODE_ERODE:    win_val = win_min;
         MODE_GRADIENT: win_val = win_max - win_min;
         default:       win_val = win_max;
      endcase
   end

   //---------------------------------------------------------------- results of stage 1
   always_comb begin
      // slot 0: window center one row up and one column left
      res_in[0].row   = s1_row_ff - 1'b1;
      res_in[0].col   = s1_col_ff - 1'b1;
      res_in[0].value = (s1_flags_ff.r_ge2 && s1_flags_ff.c_ge2) ? win_val : near_col.middle;
      // slot 1: right border pixel of the row above
      res_in[1].row   = s1_row_ff - 1'b1;
      res_in[1].col   = s1_col_ff;
      res_in[1].value = lb_q.middle;
      // slot 2: pass-through on the last row
      res_in[2].row   = s1_row_ff;
      res_in[2].col   = s1_col_ff;
      res_in[2].value = s1_pix_ff;

      new_mask[0] = s1_flags_ff.r_ge1 & s1_flags_ff.c_ge1;
      new_mask[1] = s1_flags_ff.r_ge1 & s1_flags_ff.c_last;
      new_mask[2] = s1_flags_ff.r_last;
   end

   always_comb begin
      pend_in = pend_ff;
      if (load) begin
         pend_in = new_mask;
      end else if (rsp_take) begin
         pend_in = pend_left;
      end
   end

   assign s1_valid_in = accept_in ? 1'b1 : (load ? 1'b0 : s1_valid_ff);

   //---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_DILATE;
         last_col_ff <= COL_BITS'(RESET_WIDTH - 1);
         last_row_ff <= ROW_BITS'(RESET_HEIGHT - 1);
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         pend_ff     <= '0;
      end else begin
         mode_ff     <= mode_in;
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         pend_ff     <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_in) begin
         s1_pix_ff   <= req_tdata[PIXEL_BITS-1:0];
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
         s1_flags_ff <= flags_now;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff[0] <= res_in[0];
         res_ff[1] <= res_in[1];
         res_ff[2] <= res_in[2];
      end
   end

   //---------------------------------------------------------------- result beat
   always_comb begin
      res_out = res_ff[0];
      if (sel[1]) begin
         res_out = res_ff[1];
      end else if (sel[2]) begin
         res_out = res_ff[2];
      end
   end

   assign rsp_tvalid = (pend_ff != 3'b000);
   assign rsp_tlast  = (pend_left == 3'b000);
   assign rsp_tdata  = {(RSP_DATA_BITS - OUT_ROW_BITS - OUT_COL_BITS - VALUE_BITS)'(0),
                        VALUE_BITS'(res_out.value),
                        OUT_COL_BITS'(res_out.col),
                        OUT_ROW_BITS'(res_out.row)};

endmodule

// File: hdl/gm3_line_buffer.sv
module gm3_line_buffer
   import gm3_pkg::*;
(
   input  logic          clock,
   input  logic          rd_en,
   input  col_type       rd_addr,
   output line_pair_type rd_data,
   input  logic          wr_en,
   input  col_type       wr_addr,
   input  line_pair_type wr_data
);

   line_pair_type mem [MAX_WIDTH];
   line_pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // write-first on a same-address collision (one-column frames)
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/gm3_column_cell.sv
module gm3_column_cell
   import gm3_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       shift_en,
   input  column_type col_in,
   output column_type col_out,
   output pixel_type  col_max,
   output pixel_type  col_min
);

   column_type col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (shift_en) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;
   assign col_max = column_max(col_ff);
   assign col_min = column_min(col_ff);

endmodule

// File: verif/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gm3_pkg::*;

   localparam int SETTLE_CYCLES  = 8;        // pipeline flush before a register write
   localparam int RANDOM_ITEMS   = 110;
   localparam int CYCLE_LIMIT    = 500_000;
   localparam int DIRECTED_ROWS  = 33;
   localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;   // decodes as dilation

   // one result beat, as unpacked from rsp_tdata and rsp_tlast
   typedef struct packed {
      logic      last;
      pixel_type value;
      col_type   col;
      row_type   row;
   } morph_beat_type;

   typedef enum logic {ROW_PIXEL, ROW_CSR} row_kind_type;

   // directed row: a register write or a pixel, with an optional hand-typed result
   typedef struct packed {
      row_kind_type              kind;
      logic [CSR_IDX_BITS-1:0]   idx;
      logic [CSR_BITS-1:0]       data;
      pixel_type                 px;
      logic                      typed;
      row_type                   row;
      col_type                   col;
      pixel_type                 val;
   } stim_row_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tlast;
   logic                     csr_we     = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index  = '0;
   logic [CSR_BITS-1:0]      csr_wdata  = '0;

   // shadow of the block: configuration, line buffers, window and position
   logic [MODE_BITS-1:0]  cfg_mode   = MODE_DILATE;
   logic [WIDTH_BITS-1:0] cfg_width  = WIDTH_BITS'(RESET_WIDTH);
   logic [ROW_BITS-1:0]   cfg_height = ROW_BITS'(RESET_HEIGHT);
   pixel_type             line_upper  [MAX_WIDTH] = '{default: '0};
   pixel_type             line_middle [MAX_WIDTH] = '{default: '0};
   pixel_type             win_col     [6]         = '{default: '0};
   row_type               row_pos = '0;
   col_type               col_pos = '0;

   morph_beat_type filtered_q [$];   // results owed by the block, oldest first

   bit calm           = 1'b0;     // no gaps on either side while set
   int stall_left     = 0;
   int cycle_count    = 0;
   int error_count    = 0;
   int pixels_sent    = 0;
   int results_seen   = 0;
   int csr_writes     = 0;

   // directed part: tiny frames first, then one 6x3 frame that swaps mode mid-row
   stim_row_type directed_tab [DIRECTED_ROWS] = '{
      // single-row frame of width 3: every pixel passes straight through
      '{ROW_CSR,   CSR_HEIGHT, 16'd1,      8'h00, 1'b0, 16'd0, 10'd0, 8'h00},
      '{ROW_CSR,   CSR_WIDTH,  16'd3,      8'h00, 1'b0, 16'd0, 10'd0, 8'h00},
      '{ROW_PIXEL, CSR_MODE,   16'd0,      8'h00, 1'b1, 16'd0, 10'd0, 8'h00},
      '{ROW_PIXEL, CSR_MODE,   16'd0,      8'hFF, 1'b1, 16'd0, 10'd1, 8'hFF},
      '{ROW_PIXEL, CSR_MODE,   16'd0,      8'h5A, 1'b1, 16'd0, 10'd2, 8'h5A},
      // frame wraps back to the origin
      '{ROW_PIXEL, CSR_MODE,   16'd0,      8'h81, 1'b1, 16'd0, 10'd0, 8'h81},
      // zero width and zero height both count as one; upper width bits are ignored
      '{ROW_CSR,   CSR_WIDTH,  16'hF800,   8'h00, 1'b0, 16'd0, 10'd0, 8'h00},
      '{ROW_CSR,   CSR_HEIGHT, 16'd0,      8'h00, 1'b0, 16'd0, 10'd0, 8'h00},
      '{ROW_PIXEL, CSR_MODE,   16'd0,      8'h33, 1'b1, 16'd0, 10'd0, 8'h33},
      // 6x3 frame, dilation for the first interior pixel
      '{ROW_CSR,   CSR_MODE,   16'(MODE_DILATE),   8'h00, 1'b0, 16'd0, 10'd0, 8'h00},
      '{ROW_CSR,   CSR_WIDTH,  16'd6,      8'h00, 1'b0, 16'd0, 10'd0, 8'h00},
      '{ROW_CSR,   CSR_HEIGHT, 16'd3,      8'h00, 1'b0, 16'd0, 10'd0, 8'h00},
      '{ROW_PIXEL, CSR_MODE,   16'd0,      8'h10, 1'b0, 16'd0, 10'd0, 8'h00},
      '{ROW_PIXEL, CSR_MODE,   16'd0,      8'hF0, 1'b0, 16'd0, 10'd0, 8'h00},
      '{ROW_PIXEL, CSR_MODE,   16'd0,      8'h00, 1'b0, 16'd0, 10'd0, 8'h00},
      '{ROW_PIXEL, CSR_MODE,   16'd0,      8'hFF, 1'b0, 16'd0, 10'd0, 8'h00},
      '{ROW_PIXEL, CSR_MODE,   16'd0,      8'h80, 1'b0, 16'd0, 10'd0, 8'h00},
      '{ROW_PIXEL, CSR_MODE,   16'd0,      8'h7F, 1'b0, 16'd0, 10'd0, 8'h00},
      '{ROW_PIXEL, CSR_MODE,   16'd0,      8'h20, 1'b0, 16'd0, 10'd0, 8'h00},
      '{ROW_PIXEL, CSR_MODE,   16'd0,      8'hE0, 1'b0, 16'd0, 10'd0, 8'h00},
      '{ROW_PIXEL, CSR_MODE,   16'd0,      8'h01, 1'b0, 16'd0, 10'd0, 8'h00},
      '{ROW_PIXEL, CSR_MODE,   16'd0,      8'hFE, 1'b0, 16'd0, 10'd0, 8'h00},
      '{ROW_PIXEL, CSR_MODE,   16'd0,      8'h55, 1'b0, 16'd0, 10'd0, 8'h00},
      '{ROW_PIXEL, CSR_MODE,   16'd0,      8'hAA, 1'b0, 16'd0, 10'd0, 8'h00},
      '{ROW_PIXEL, CSR_MODE,   16'd0,      8'h30, 1'b0, 16'd0, 10'd0, 8'h00},
      '{ROW_PIXEL, CSR_MODE,   16'd0,      8'h40, 1'b0, 16'd0, 10'd0, 8'h00},
      '{ROW_PIXEL, CSR_MODE,   16'd0,      8'h0F, 1'b0, 16'd0, 10'd0, 8'h00},
      // mode changes mid-frame keep the position
      '{ROW_CSR,   CSR_MODE,   16'(MODE_ERODE),    8'h00, 1'b0, 16'd0, 10'd0, 8'h00},
      '{ROW_PIXEL, CSR_MODE,   16'd0,      8'hC3, 1'b0, 16'd0, 10'd0, 8'h00},
      '{ROW_CSR,   CSR_MODE,   16'(MODE_GRADIENT), 8'h00, 1'b0, 16'd0, 10'd0, 8'h00},
      '{ROW_PIXEL, CSR_MODE,   16'd0,      8'h3C, 1'b0, 16'd0, 10'd0, 8'h00},
      '{ROW_CSR,   CSR_MODE,   16'(MODE_UNUSED),   8'h00, 1'b0, 16'd0, 10'd0, 8'h00},
      // last pixel of the frame gives interior, row end and its own pass-through
      '{ROW_PIXEL, CSR_MODE,   16'd0,      8'h99, 1'b0, 16'd0, 10'd0, 8'h00}
   };

   gray_morphology_3x3_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly no gap, some short ones, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 8);
      return $urandom_range(12, 20);
   endfunction

   // gray level with extra weight on black and white
   function automatic pixel_type pick_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return pixel_type'($urandom_range(0, 255));
      endcase
   endfunction

   // width word with junk in the bits above the register
   function automatic logic [CSR_BITS-1:0] width_word(input int w);
      return {(CSR_BITS-WIDTH_BITS)'($urandom_range(0, 31)), WIDTH_BITS'(w)};
   endfunction

   // one pixel through the shadow block; keep queues the results it causes
   task automatic filter_pixel(input pixel_type px, input bit keep);
      int unsigned    w, h, r, c;
      int             n;
      pixel_type      nb [9];
      pixel_type      hi, lo, val;
      morph_beat_type outs [3];
      w = cfg_width;
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = (cfg_height == 0) ? 1 : cfg_height;
      r = row_pos;
      c = col_pos;
      if (c >= w) c = w - 1;
      if (r >= h) r = h - 1;
      // columns c-2, c-1 from the window, column c from the lines and the new pixel
      for (int i = 0; i < 6; i++) nb[i] = win_col[i];
      nb[6] = line_upper[c];
      nb[7] = line_middle[c];
      nb[8] = px;
      n = 0;
      if (r >= 1 && c >= 1) begin
         if (r >= 2 && c >= 2) begin
            hi = '0;
            lo = '1;
            for (int i = 0; i < 9; i++) begin
               if (nb[i] > hi) hi = nb[i];
               if (nb[i] < lo) lo = nb[i];
            end
            if (cfg_mode == MODE_ERODE) val = lo;
            else if (cfg_mode == MODE_GRADIENT) val = hi - lo;
            else val = hi;
         end else begin
            // left or top border of the previous row passes through
            val = win_col[4];
         end
         outs[n] = '{last: 1'b0, value: val, col: col_type'(c - 1), row: row_type'(r - 1)};
         n++;
      end
      if (r >= 1 && c == w - 1) begin
         outs[n] = '{last: 1'b0, value: nb[7], col: col_type'(w - 1), row: row_type'(r - 1)};
         n++;
      end
      if (r == h - 1) begin
         outs[n] = '{last: 1'b0, value: px, col: col_type'(c), row: row_type'(r)};
         n++;
      end
      if (n > 0) outs[n-1].last = 1'b1;
      if (keep) for (int i = 0; i < n; i++) filtered_q.push_back(outs[i]);
      line_upper[c]  = nb[7];
      line_middle[c] = px;
      for (int i = 0; i < 3; i++) begin
         win_col[i]   = win_col[i+3];
         win_col[i+3] = nb[6+i];
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = col_type'(c);
      row_pos = row_type'(r);
   endtask

   // register write, mirrored into the shadow configuration
   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_MODE: cfg_mode = data[MODE_BITS-1:0];
         CSR_WIDTH: begin
            cfg_width = data[WIDTH_BITS-1:0];
            row_pos   = '0;
            col_pos   = '0;
         end
         CSR_HEIGHT: begin
            cfg_height = data[ROW_BITS-1:0];
            row_pos    = '0;
            col_pos    = '0;
         end
         default: ;
      endcase
      csr_writes++;
   endtask

   // hold the sender until every owed result has left, then let the pipe settle
   task automatic wait_idle(input int settle);
      if (req_tvalid) req_tvalid <= 1'b0;
      while (filtered_q.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // one pixel beat; typed rows owe the hand-written result instead of the predicted ones
   task automatic send_pixel(input pixel_type px, input bit typed,
                             input morph_beat_type typed_beat);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      filter_pixel(px, !typed);
      if (typed) filtered_q.push_back(typed_beat);
      pixels_sent++;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // new mode, optionally a new frame size, then a run of pixels
   task automatic run_phase(input logic [CSR_BITS-1:0] width_data,
                            input logic [CSR_BITS-1:0] height_data,
                            input int count, input bit mode_only);
      wait_idle(SETTLE_CYCLES);
      csr_write(CSR_MODE, CSR_BITS'($urandom_range(0, 65535)));
      if (!mode_only) begin
         csr_write(CSR_WIDTH, width_data);
         csr_write(CSR_HEIGHT, height_data);
      end
      repeat (count) begin
         send_pixel(pick_pixel(), 1'b0, '0);
         // now and then drain the block completely before going on
         if (!calm && $urandom_range(0, 59) == 0) wait_idle(1);
      end
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // result side: random back-pressure, calm stretches keep tready high
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (calm || $urandom_range(0, 3) != 0) begin
         rsp_tready <= 1'b1;
      end else begin
         stall_left <= pick_gap();
         rsp_tready <= 1'b0;
      end
   end

   // every accepted result beat against the oldest owed one
   always @(posedge clock) begin : check_results
      morph_beat_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.row   = rsp_tdata[OUT_ROW_BITS-1:0];
         got.col   = rsp_tdata[OUT_ROW_BITS +: OUT_COL_BITS];
         got.value = rsp_tdata[OUT_ROW_BITS+OUT_COL_BITS +: VALUE_BITS];
         got.last  = rsp_tlast;
         results_seen++;
         if (filtered_q.size() == 0) begin
            $display("%0t: unexpected result beat, row %0d col %0d value %0d",
                     $time, got.row, got.col, got.value);
            error_count++;
         end else begin
            want = filtered_q.pop_front();
            compare_field("row", want.row, got.row);
            compare_field("col", want.col, got.col);
            compare_field("value", want.value, got.value);
            compare_field("last", want.last, got.last);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, filtered_q.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin : stimulus
      morph_beat_type typed_beat;
      int             random_items;
      int             w, h, count;
      bit             mode_only;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_tab[k]) begin
         if (directed_tab[k].kind == ROW_CSR) begin
            wait_idle(SETTLE_CYCLES);
            csr_write(directed_tab[k].idx, directed_tab[k].data);
         end else begin
            typed_beat = '{last: 1'b1, value: directed_tab[k].val,
                           col: directed_tab[k].col, row: directed_tab[k].row};
            send_pixel(directed_tab[k].px, directed_tab[k].typed, typed_beat);
         end
      end

      // widest frame, single row, full speed on both sides
      calm = 1'b1;
      run_phase(width_word(MAX_WIDTH), 16'd1, 8, 1'b0);
      calm = 1'b0;
      // width above the maximum clamps, single-row frame
      run_phase(width_word($urandom_range(MAX_WIDTH + 1, 2047)), 16'd1, 6, 1'b0);
      // tallest frame, only its first rows
      run_phase(width_word(3), 16'hFFFF, 15, 1'b0);
      // zero width with junk above it counts as one column
      run_phase({(CSR_BITS-WIDTH_BITS)'(5'h1F), WIDTH_BITS'(0)},
                CSR_BITS'($urandom_range(2, 4)), 8, 1'b0);

      // small random frames, some only changing mode mid-frame
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         calm = ($urandom_range(0, 4) == 0);
         w = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         h = $urandom_range(1, 6);
         mode_only = ($urandom_range(0, 3) == 0);
         if (mode_only) begin
            count = $urandom_range(1, 12);
         end else begin
            count = $urandom_range(0, 1) ? w * h : $urandom_range(1, w * h + w);
         end
         if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;
         run_phase(width_word(w), CSR_BITS'(h), count, mode_only);
         random_items += count;
      end
      calm = 1'b0;

      wait_idle(SETTLE_CYCLES);
      $display("covered %0d pixel beats and %0d result beats over %0d register writes",
               pixels_sent, results_seen, csr_writes);
      $display("all four mode codes, widths 1 to 1024 with clamping, heights 1 to 65535");
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
